// ===== rtl/sem_pkg.sv =====
// Shared types, constants and codes of the Sobel edge magnitude block.
`default_nettype none
package sem_pkg;

	localparam int MaxWidth   = 1024;
	localparam int MaxHeight  = 1024;
	localparam int LineDepth  = MaxWidth;
	localparam int ColW       = $clog2(MaxWidth);
	localparam int DimW       = 11;
	localparam int RowW       = 11;
	localparam int IdxW       = 21;
	localparam int AddrW      = 3;
	localparam int DataW      = 32;
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int GradW      = 12;
	localparam int SumW       = 21;
	localparam int RootW      = 8;
	localparam int RootCntW   = $clog2(RootW);
	localparam int NumChan    = 3;

	localparam logic OPC_PIXEL = 1'b0;
	localparam logic OPC_FLUSH = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [DimW-1:0] WidthReset  = DimW'(640);
	localparam logic [DimW-1:0] HeightReset = DimW'(480);

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [DimW-1:0] w;
		logic [DimW-1:0] h;
		logic [IdxW-1:0] wh;
		logic [IdxW-1:0] total;
	} sem_dims_t;

	typedef struct packed {
		pixel_t          pix;
		logic [ColW-1:0] col;
		logic            has_out;
		logic            ok_row_top;
		logic            ok_row_bot;
		logic            ok_col_left;
		logic            ok_col_right;
		logic            last;
	} sem_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_GRAD,
		ST_SQR,
		ST_ROOT,
		ST_OUT
	} sem_state_t;

endpackage
`default_nettype wire

// ===== rtl/sem_queue.sv =====
// Small FIFO that decouples the classifying front end from the compute back end.
`default_nettype none
module sem_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  sem_pkg::sem_item_t push_item,
	input  wire                pop,
	output sem_pkg::sem_item_t head_item,
	output logic               full,
	output logic               empty
);
	import sem_pkg::*;

	sem_item_t           mem_q [QueueDepth];
	logic [QPtrW-1:0]    wr_ptr_q;
	logic [QPtrW-1:0]    rd_ptr_q;
	logic [QPtrW:0]      count_q;

	assign full      = (count_q == (QPtrW+1)'(QueueDepth));
	assign empty     = (count_q == '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sem_front.sv =====
// Front end: accepts input transactions, tracks the raster position and classifies each item.
`default_nettype none
module sem_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 restart,
	input  sem_pkg::sem_dims_t  dims,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 opcode,
	input  wire  [7:0]          pixel_blue,
	input  wire  [7:0]          pixel_green,
	input  wire  [7:0]          pixel_red,
	input  wire                 q_full,
	output logic                push,
	output sem_pkg::sem_item_t  item
);
	import sem_pkg::*;

	logic              settle_q;
	logic [IdxW-1:0]   idx_q;
	logic [ColW-1:0]   col_q;
	logic [RowW-1:0]   row_q;

	logic              col_zero;
	logic [DimW-1:0]   w_m1;
	logic [ColW-1:0]   pc;
	logic [RowW-1:0]   pr;
	logic [IdxW-1:0]   idx_nxt;
	logic [DimW-1:0]   col_nxt;

	// Input is stalled while the registered dimensions settle after reset or a register write.
	assign in_stall = settle_q | q_full;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		col_zero = (col_q == '0);
		w_m1     = dims.w - 1'b1;
		pc       = col_zero ? w_m1[ColW-1:0] : col_q - 1'b1;
		pr       = col_zero ? row_q - RowW'(2) : row_q - RowW'(1);
		idx_nxt  = idx_q + 1'b1;
		col_nxt  = {1'b0, col_q} + 1'b1;

		item.pix          = ((opcode == OPC_PIXEL) && (idx_q < dims.wh)) ?
		                    {pixel_red, pixel_green, pixel_blue} : '0;
		item.col          = col_q;
		item.has_out      = (idx_q >= (IdxW'(dims.w) + 1'b1));
		item.ok_row_top   = (pr != '0);
		item.ok_row_bot   = (({1'b0, pr} + 1'b1) < {1'b0, dims.h});
		item.ok_col_left  = (pc != '0);
		item.ok_col_right = (({1'b0, pc} + 1'b1) < dims.w);
		item.last         = (idx_nxt == dims.total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 1'b1;
			idx_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			settle_q <= restart;
			if (restart) begin
				idx_q <= '0;
				col_q <= '0;
				row_q <= '0;
			end else if (push) begin
				if (idx_nxt >= dims.total) begin
					idx_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					idx_q <= idx_nxt;
					if (col_nxt >= dims.w) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_nxt[ColW-1:0];
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sem_root.sv =====
// Iterative rounded square root, one result bit per cycle, saturating at the top code.
`default_nettype none
module sem_root (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  [sem_pkg::SumW-1:0]   sum,
	output logic                       busy,
	output logic [sem_pkg::RootW-1:0]  root
);
	import sem_pkg::*;

	logic                 busy_q;
	logic [RootCntW-1:0]  cnt_q;
	logic [RootW-1:0]     m_q;
	logic [SumW-1:0]      s_q;

	logic [RootW-1:0]     trial;
	logic [2*RootW:0]     prod;

	// The answer is the smallest k with k*(k+1) >= s; the search finds the
	// largest m with m*(m+1) < s and the result is m+1.
	always_comb begin
		trial = m_q | (RootW'(1) << cnt_q);
		prod  = (2*RootW+1)'(trial) * (2*RootW+1)'({1'b0, trial} + 1'b1);
	end

	assign busy = busy_q;
	assign root = (s_q == '0) ? '0 : ((m_q == '1) ? m_q : m_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= RootCntW'(RootW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= sum;
			m_q <= '0;
		end else if (busy_q && (SumW'(prod) < s_q)) begin
			m_q <= trial;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sem_back.sv =====
// Back end: line buffers, 3x3 window, Sobel gradients, magnitude and output handshake.
`default_nettype none
module sem_back (
	input  wire                clk,
	input  wire                arst_n,
	input  sem_pkg::sem_item_t q_item,
	input  wire                q_empty,
	output logic               pop,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [7:0]         edge_blue,
	output logic [7:0]         edge_green,
	output logic [7:0]         edge_red,
	output logic               frame_last
);
	import sem_pkg::*;

	sem_state_t  state_q;
	sem_state_t  state_nxt;

	pixel_t      upper_mem [LineDepth];
	pixel_t      lower_mem [LineDepth];
	pixel_t      up_rd_q;
	pixel_t      lo_rd_q;
	sem_item_t   ent_q;
	pixel_t      win_q [3][3];

	logic signed [GradW-1:0]   gx_q [NumChan];
	logic signed [GradW-1:0]   gy_q [NumChan];
	logic signed [GradW-1:0]   gx_c [NumChan];
	logic signed [GradW-1:0]   gy_c [NumChan];
	logic        [SumW-1:0]    sum_c [NumChan];
	logic        [RootW-1:0]   root_res [NumChan];
	logic        [NumChan-1:0] root_busy;

	logic rd_en;
	logic wr_en;
	logic grad_en;
	logic root_start;

	always_comb begin
		case (state_q)
			ST_IDLE:  state_nxt = q_empty ? ST_IDLE : ST_SHIFT;
			ST_SHIFT: state_nxt = ent_q.has_out ? ST_GRAD : ST_IDLE;
			ST_GRAD:  state_nxt = ST_SQR;
			ST_SQR:   state_nxt = ST_ROOT;
			ST_ROOT:  state_nxt = (root_busy != '0) ? ST_ROOT : ST_OUT;
			ST_OUT:   state_nxt = out_stall ? ST_OUT : ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en      = (state_q == ST_IDLE) && !q_empty;
		wr_en      = (state_q == ST_SHIFT);
		grad_en    = (state_q == ST_GRAD);
		root_start = (state_q == ST_SQR);
		out_valid  = (state_q == ST_OUT);
		pop        = rd_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Line buffers: read in the pop cycle, rotated in the cycle after it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_rd_q <= upper_mem[q_item.col];
			lo_rd_q <= lower_mem[q_item.col];
			ent_q   <= q_item;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[ent_q.col] <= lo_rd_q;
			lower_mem[ent_q.col] <= ent_q.pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (wr_en) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_rd_q;
			win_q[1][2] <= lo_rd_q;
			win_q[2][2] <= ent_q.pix;
		end
	end

	// Neighbors outside the frame are masked to zero before the kernels.
	always_comb begin
		logic                    row_ok [3];
		logic                    col_ok [3];
		logic signed [GradW-1:0] v [3][3];
		logic signed [2*GradW-1:0] gxe;
		logic signed [2*GradW-1:0] gye;
		logic        [2*GradW-1:0] sq;
		row_ok[0] = ent_q.ok_row_top;
		row_ok[1] = 1'b1;
		row_ok[2] = ent_q.ok_row_bot;
		col_ok[0] = ent_q.ok_col_left;
		col_ok[1] = 1'b1;
		col_ok[2] = ent_q.ok_col_right;
		for (int ch = 0; ch < NumChan; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					v[i][j] = (row_ok[i] && col_ok[j]) ?
					          $signed({4'b0, win_q[i][j][8*ch +: 8]}) : '0;
				end
			end
			gx_c[ch] = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) +
			           (v[2][2] - v[2][0]);
			gy_c[ch] = (v[2][0] - v[0][0]) + ((v[2][1] - v[0][1]) <<< 1) +
			           (v[2][2] - v[0][2]);
			gxe       = (2*GradW)'(gx_q[ch]);
			gye       = (2*GradW)'(gy_q[ch]);
			sq        = gxe * gxe + gye * gye;
			sum_c[ch] = sq[SumW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (grad_en) begin
			for (int ch = 0; ch < NumChan; ch++) begin
				gx_q[ch] <= gx_c[ch];
				gy_q[ch] <= gy_c[ch];
			end
		end
	end

	for (genvar ch = 0; ch < NumChan; ch++) begin : g_root
		sem_root u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (root_start),
			.sum    (sum_c[ch]),
			.busy   (root_busy[ch]),
			.root   (root_res[ch])
		);
	end

	assign edge_blue  = root_res[0];
	assign edge_green = root_res[1];
	assign edge_red   = root_res[2];
	assign frame_last = ent_q.last;

endmodule
`default_nettype wire

// ===== rtl/sobel_edge_magnitude_rgb_unit.sv =====
// Latency: a pixel's result leaves with the transaction width+1 items after it; out_valid
// rises once that transaction has passed the queue and the shift, gradient, square and root states.
// Pacing: the back end takes one item at a time from the queue; items with a result also pass the 8-step root search.
// The input queue keeps taking transactions while a result waits for the output side, until the queue is full.
// Reset clears the raster position, window and control; line buffers are not cleared.
// Input is stalled for one cycle after reset and after each register write.
`default_nettype none
module sobel_edge_magnitude_rgb_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [sem_pkg::AddrW-1:0]   paddr,
	input  wire  [sem_pkg::DataW-1:0]   pwdata,
	output logic [sem_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         opcode,
	input  wire  [7:0]                  pixel_blue,
	input  wire  [7:0]                  pixel_green,
	input  wire  [7:0]                  pixel_red,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [7:0]                  edge_blue,
	output logic [7:0]                  edge_green,
	output logic [7:0]                  edge_red,
	output logic                        frame_last
);
	import sem_pkg::*;

	logic [DimW-1:0] frame_width_q;
	logic [DimW-1:0] frame_height_q;
	logic            cfg_wr;
	logic            reg_sel;
	logic [DimW-1:0] eff_w;
	logic [DimW-1:0] eff_h;
	logic [2*DimW-1:0] area;
	sem_dims_t       dims_q;

	sem_item_t       push_item;
	sem_item_t       head_item;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	// Configuration writes complete in the access phase; there are no wait states.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_sel = paddr[AddrW-1];
	assign prdata  = (reg_sel == REG_HEIGHT) ? DataW'(frame_height_q) : DataW'(frame_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WidthReset;
			frame_height_q <= HeightReset;
		end else if (cfg_wr) begin
			if (reg_sel == REG_WIDTH) begin
				frame_width_q <= pwdata[DimW-1:0];
			end else begin
				frame_height_q <= pwdata[DimW-1:0];
			end
		end
	end

	// A zero dimension acts as one, and large values clamp to MaxWidth and MaxHeight.
	always_comb begin
		eff_w = (frame_width_q == '0) ? DimW'(1) :
		        ((frame_width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : frame_width_q);
		eff_h = (frame_height_q == '0) ? DimW'(1) :
		        ((frame_height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : frame_height_q);
		area  = eff_w * eff_h;
	end

	// Frame geometry is registered; the front end holds off for the cycle it takes to settle.
	always_ff @(posedge clk) begin
		dims_q.w     <= eff_w;
		dims_q.h     <= eff_h;
		dims_q.wh    <= area[IdxW-1:0];
		dims_q.total <= area[IdxW-1:0] + IdxW'(eff_w) + 1'b1;
	end

	sem_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr),
		.dims        (dims_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.pixel_blue  (pixel_blue),
		.pixel_green (pixel_green),
		.pixel_red   (pixel_red),
		.q_full      (q_full),
		.push        (push),
		.item        (push_item)
	);

	sem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	sem_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_item     (head_item),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_blue  (edge_blue),
		.edge_green (edge_green),
		.edge_red   (edge_red),
		.frame_last (frame_last)
	);

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the Sobel edge magnitude block: directed, extreme and random frames.
`default_nettype none
module tb;
	import sem_pkg::*;

	// Clock, reset and every port of the block.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OPC_PIXEL;
	logic [7:0]  pixel_blue = '0, pixel_green = '0, pixel_red = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  edge_blue, edge_green, edge_red;
	logic        frame_last;

	always #10 clk = ~clk;

	sobel_edge_magnitude_rgb_unit dut (.*);

	// One expected result: three channel magnitudes and the end-of-frame flag.
	typedef struct {
		logic [7:0] blue, green, red;
		logic       last;
	} edge_result_t;

	edge_result_t pending_edges[$];

	// Shadow copy of the block's state, advanced on each accepted input transaction.
	logic [DimW-1:0] shadow_width = WidthReset, shadow_height = HeightReset;
	pixel_t line_upper[MaxWidth];
	pixel_t line_lower[MaxWidth];
	pixel_t window[3][3];
	int     raster_col, raster_row, frame_items;

	int     fail_count = 0;
	int     items_sent = 0, edges_checked = 0, frames_done = 0, reg_writes = 0;
	int     idle_cycles = 0;
	bit     burst_mode = 1'b1;
	int     burst_left = 0;

	function automatic int clamp_dim(logic [DimW-1:0] v, int max_dim);
		if (v == 0) return 1;
		return (v > max_dim) ? max_dim : int'(v);
	endfunction

	// Rounded square root: smallest k with s <= k*(k+1), capped at 255.
	function automatic logic [7:0] rounded_root(int s);
		int k;
		k = 0;
		while (k < 255 && s > (k + 1) * k) k++;
		return 8'(k);
	endfunction

	function automatic void restart_raster();
		raster_col = 0;
		raster_row = 0;
		frame_items = 0;
	endfunction

	// Shift one transaction into the line buffers and window and queue its result, if any.
	function automatic void predict_edge(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
		int w, h, total, col, pc, pr, gx, gy, v;
		pixel_t pix, up, lo;
		bit ok_row[3], ok_col[3];
		logic [7:0] mag[3];
		edge_result_t res;
		w = clamp_dim(shadow_width, MaxWidth);
		h = clamp_dim(shadow_height, MaxHeight);
		total = w * h + w + 1;
		col = raster_col;
		// Pixels after the frame's last one act as flushes, and early flushes as black.
		pix = (op == OPC_PIXEL && frame_items < w * h) ? {r, g, b} : '0;
		up = line_upper[col];
		lo = line_lower[col];
		line_upper[col] = lo;
		line_lower[col] = pix;
		for (int i = 0; i < 3; i++) begin
			window[i][0] = window[i][1];
			window[i][1] = window[i][2];
		end
		window[0][2] = up;
		window[1][2] = lo;
		window[2][2] = pix;
		if (frame_items >= w + 1) begin
			pc = (col == 0) ? w - 1 : col - 1;
			pr = (col == 0) ? raster_row - 2 : raster_row - 1;
			ok_row = '{pr > 0, 1'b1, pr + 1 < h};
			ok_col = '{pc > 0, 1'b1, pc + 1 < w};
			for (int ch = 0; ch < 3; ch++) begin
				gx = 0;
				gy = 0;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						if (ok_row[i] && ok_col[j]) begin
							v = int'(window[i][j][8*ch +: 8]);
							gx += v * (j - 1) * ((i == 1) ? 2 : 1);
							gy += v * (i - 1) * ((j == 1) ? 2 : 1);
						end
				mag[ch] = rounded_root(gx * gx + gy * gy);
			end
			res.blue = mag[0];
			res.green = mag[1];
			res.red = mag[2];
			res.last = (frame_items + 1 == total);
			pending_edges.push_back(res);
		end
		frame_items++;
		raster_col = col + 1;
		if (raster_col >= w) begin
			raster_col = 0;
			raster_row++;
		end
		if (frame_items >= total) begin
			restart_raster();
			frames_done++;
		end
	endfunction

	// Result side: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		edge_result_t exp_edge;
		if (out_valid && !out_stall) begin
			if (pending_edges.size() == 0) begin
				$error("unexpected result: blue %0d green %0d red %0d last %0d",
					edge_blue, edge_green, edge_red, frame_last);
				fail_count++;
			end else begin
				exp_edge = pending_edges.pop_front();
				edges_checked++;
				if (edge_blue !== exp_edge.blue) begin
					$error("edge_blue: expected %0d, got %0d", exp_edge.blue, edge_blue);
					fail_count++;
				end
				if (edge_green !== exp_edge.green) begin
					$error("edge_green: expected %0d, got %0d", exp_edge.green, edge_green);
					fail_count++;
				end
				if (edge_red !== exp_edge.red) begin
					$error("edge_red: expected %0d, got %0d", exp_edge.red, edge_red);
					fail_count++;
				end
				if (frame_last !== exp_edge.last) begin
					$error("frame_last: expected %0d, got %0d", exp_edge.last, frame_last);
					fail_count++;
				end
			end
		end
	end

	// The receiver stalls in phases: none, light, and heavy back pressure.
	always @(posedge clk) begin
		int stall_phase;
		stall_phase = ($time / 20 / 97) % 3;
		if (!arst_n || stall_phase == 0)
			out_stall <= 1'b0;
		else if (stall_phase == 1)
			out_stall <= ($urandom_range(3) == 0);
		else
			out_stall <= ($urandom_range(9) < 8);
	end

	// Watchdog: ends the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Register write in setup and access cycles, then a checked read back; the frame restarts on every write.
	task automatic write_reg(logic idx, logic [DimW-1:0] value);
		logic [DataW-1:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= AddrW'(idx) << 2;
		pwdata <= DataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback[DimW-1:0] !== value) begin
			$error("register %0d readback: expected %0d, got %0d", idx, value,
				readback[DimW-1:0]);
			fail_count++;
		end
		if (idx == REG_WIDTH) shadow_width = value;
		else shadow_height = value;
		restart_raster();
		reg_writes++;
	endtask

	// Send one input transaction, holding it until taken; gaps come between bursts.
	task automatic send_item(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = burst_mode ? 0 : $urandom_range(1, 6);
			burst_mode = ($urandom_range(3) == 0);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		pixel_blue <= b;
		pixel_green <= g;
		pixel_red <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_edge(op, b, g, r);
		items_sent++;
	endtask

	// Wait until every expected result has come, then let queued work settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_random_pixel();
		send_item(OPC_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// One frame; noise_pct percent of transactions carry the other opcode.
	task automatic send_frame(int w, int h, int noise_pct);
		for (int n = 0; n < w * h + w + 1; n++) begin
			logic op;
			op = (n < w * h) ? OPC_PIXEL : OPC_FLUSH;
			if ($urandom_range(99) < noise_pct) op = ~op;
			send_item(op, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// Directed: checkered, all-white and near-black channels, an early flush and a late pixel.
	task automatic test_directed();
		write_reg(REG_WIDTH, 11'd3);
		write_reg(REG_HEIGHT, 11'd3);
		for (int n = 0; n < 13; n++) begin
			if (n < 9)
				send_item(OPC_PIXEL, (n % 2) ? 8'hFF : 8'h00, 8'hFF, (n == 4) ? 8'hFF : 8'h00);
			else if (n == 10)
				send_item(OPC_PIXEL, 8'hAA, 8'h55, 8'hFF); // late pixel acts as flush
			else
				send_item(OPC_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		end
		// Early flush in the middle of the pixel phase counts as a black pixel.
		for (int n = 0; n < 13; n++)
			send_item((n == 4 || n >= 9) ? OPC_FLUSH : OPC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		drain();
	endtask

	// Register extremes: zero acts as one, values past the maximum saturate.
	task automatic test_register_extremes();
		write_reg(REG_WIDTH, 11'd0);
		write_reg(REG_HEIGHT, 11'd0);
		for (int f = 0; f < 3; f++) send_frame(1, 1, 0);
		drain();
		// The saturated width decides which transaction first yields a result; the
		// partial frame is cut off by the next register write.
		write_reg(REG_WIDTH, 11'h7FF);
		write_reg(REG_HEIGHT, 11'h7FF);
		repeat (MaxWidth + 4) send_random_pixel();
		drain();
	endtask

	// Random frames of small sizes, mostly well formed, some with noise or cut short.
	task automatic test_random_frames();
		int w, h, start;
		start = items_sent;
		while (items_sent - start < 740) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			write_reg(REG_WIDTH, 11'(w));
			write_reg(REG_HEIGHT, 11'(h));
			repeat ($urandom_range(1, 3)) send_frame(w, h, ($urandom_range(3) == 0) ? 10 : 0);
			// Sometimes leave a partial frame for the next register write to cut off.
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, w * h)) send_random_pixel();
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < MaxWidth; i++) begin
			line_upper[i] = '0;
			line_lower[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				window[i][j] = '0;
		restart_raster();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_frames();
		drain();
		$display("Covered %0d input transactions, %0d checked results, %0d frames,",
			items_sent, edges_checked, frames_done);
		$display("and %0d register writes including zero and saturating sizes.", reg_writes);
		if (fail_count == 0 && pending_edges.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/sem_pkg.sv
rtl/sem_queue.sv
rtl/sem_front.sv
rtl/sem_root.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude_rgb_unit.sv
tb/tb.sv
